### rtl/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

### rtl/tevq_pkg.sv
// types and constants of the tick event queue
package tevq_pkg;

   localparam int TICK_W       = 64;
   localparam int TAG_W        = 16;
   localparam int DELAY_W      = 20;
   localparam int ACTION_W     = 2;
   localparam int KIND_W       = 2;
   localparam int BUDGET_W     = 7;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [BUDGET_W-1:0] BUDGET_MAX   = 7'd64;
   localparam logic [BUDGET_W-1:0] BUDGET_MIN   = 7'd1;
   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 7'd16;

   // register index bit of the csr address
   localparam int  CSR_INDEX_BIT    = 2;
   localparam logic REG_SLICE_BUDGET = 1'b0;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_SLICE  = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK   = 2'd0,
      KIND_FIRED = 2'd1,
      KIND_IDLE  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SLICE,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [TICK_W-1:0] due;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

endpackage

### rtl/tevq_req_if.sv
// request channel of the tick event queue
interface tevq_req_if import tevq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [DELAY_W-1:0]  delay;
   logic [TAG_W-1:0]    event_tag;

   modport source (output valid, action, delay, event_tag, input ready);
   modport sink   (input valid, action, delay, event_tag, output ready);
endinterface

### rtl/tevq_rsp_if.sv
// response channel of the tick event queue
interface tevq_rsp_if import tevq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [TAG_W-1:0]  fired_tag;
   logic              queue_full;
   logic              due_remaining;
   logic              tick_advanced;
   logic              last;

   modport source (output valid, kind, fired_tag, queue_full, due_remaining,
                   tick_advanced, last, input ready);
   modport sink   (input valid, kind, fired_tag, queue_full, due_remaining,
                   tick_advanced, last, output ready);
endinterface

### rtl/tevq_cell.sv
// one slot of the sorted shift chain
module tevq_cell import tevq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  entry_type     new_entry,
   input  entry_type     left_entry,
   input  logic          left_keep,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // entry stays put when it is due no later than the new one
   assign keep  = occupied && (entry_ff.due <= new_entry.due);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = right_entry;
      end else if (ctrl.insert && !keep) begin
         entry_in = left_keep ? new_entry : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### rtl/tick_event_queue.sv
// tick event queue top level: a row of QUEUE_DEPTH cells holds the events
// sorted by due tick, head in cell 0. An insert or a clear is accepted in
// the idle state, where the due tick is formed; then, with the response
// register free, an insert shifts the cell chain and a clear empties the
// queue. A slice pops one event per cycle while the response register is
// free, one result per fired event, or one nothing-due result. A new item
// is taken only once all results of the previous one have entered the
// response register. The queue needs no clearing pass after reset.
module tick_event_queue import tevq_pkg::*; #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   tevq_req_if.sink              req_chan,
   tevq_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

`include "assert_macros.svh"

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type state_ff, state_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [BUDGET_W-1:0] fired_ff, fired_in;
   entry_type           pend_ff, pend_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              rsp_due_ff, rsp_due_in;
   logic              rsp_adv_ff, rsp_adv_in;
   logic              rsp_last_ff, rsp_last_in;

   entry_type     entries [QUEUE_DEPTH];
   logic          keeps   [QUEUE_DEPTH];
   cell_ctrl_type ctrl;

   logic                accept, out_free, head_due, next_due, queue_full, pop_last;
   logic                csr_write;
   logic [BUDGET_W-1:0] budget_eff;

   logic              emit, emit_full, emit_due, emit_adv, emit_last;
   kind_type          emit_kind;
   logic [TAG_W-1:0]  emit_tag;

   // cell chain
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_keep;
      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_keep  = 1'b1;
      end else begin : g_body
         assign left_entry = entries[i-1];
         assign left_keep  = keeps[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end
      tevq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (count_ff > CNT_W'(i)),
         .new_entry   (pend_ff),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .keep        (keeps[i])
      );
   end

   assign accept     = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign head_due   = (count_ff != '0) && (entries[0].due <= tick_ff);
   assign next_due   = (count_ff > CNT_W'(1)) && (entries[1].due <= tick_ff);
   assign queue_full = count_ff == CNT_W'(QUEUE_DEPTH);

   always_comb begin
      budget_eff = budget_ff;
      if (budget_ff == '0) begin
         budget_eff = BUDGET_MIN;
      end else if (budget_ff > BUDGET_MAX) begin
         budget_eff = BUDGET_MAX;
      end
   end

   assign pop_last = ((fired_ff + BUDGET_W'(1)) >= budget_eff) || !next_due;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.action)
                  ACT_INSERT: state_in = ST_INSERT;
                  ACT_SLICE:  state_in = ST_SLICE;
                  ACT_CLEAR:  state_in = ST_CLEAR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_INSERT, ST_CLEAR: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_SLICE: begin
            if (out_free && (!head_due || pop_last)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_chan.ready = 1'b0;
      ctrl           = '0;
      emit           = 1'b0;
      emit_kind      = KIND_ACK;
      emit_tag       = '0;
      emit_full      = 1'b0;
      emit_due       = 1'b0;
      emit_adv       = 1'b0;
      emit_last      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_INSERT: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_kind   = KIND_ACK;
               emit_full   = queue_full;
               emit_last   = 1'b1;
               ctrl.insert = !queue_full;
            end
         end
         ST_CLEAR: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = KIND_CLEAR;
               emit_last = 1'b1;
            end
         end
         ST_SLICE: begin
            if (out_free) begin
               emit = 1'b1;
               if (head_due) begin
                  emit_kind = KIND_FIRED;
                  emit_tag  = entries[0].tag;
                  ctrl.pop  = 1'b1;
                  if (pop_last) begin
                     emit_last = 1'b1;
                     emit_due  = next_due;
                     emit_adv  = !next_due;
                  end
               end else begin
                  emit_kind = KIND_IDLE;
                  emit_last = 1'b1;
                  emit_adv  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      tick_in = emit_adv ? tick_ff + TICK_W'(1) : tick_ff;

      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end else if (emit && (emit_kind == KIND_CLEAR)) begin
         count_in = '0;
      end

      fired_in = fired_ff;
      if (accept) begin
         fired_in = '0;
      end else if (ctrl.pop) begin
         fired_in = fired_ff + BUDGET_W'(1);
      end

      pend_in = pend_ff;
      if (accept) begin
         pend_in.due = tick_ff + TICK_W'(req_chan.delay);
         pend_in.tag = req_chan.event_tag;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_due_in   = rsp_due_ff;
      rsp_adv_in   = rsp_adv_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_tag_in   = emit_tag;
         rsp_full_in  = emit_full;
         rsp_due_in   = emit_due;
         rsp_adv_in   = emit_adv;
         rsp_last_in  = emit_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // csr port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign budget_in  = (csr_write && (csr_paddr[CSR_INDEX_BIT] == REG_SLICE_BUDGET)) ?
                       csr_pwdata[BUDGET_W-1:0] : budget_ff;
   assign csr_prdata = (csr_paddr[CSR_INDEX_BIT] == REG_SLICE_BUDGET) ?
                       CSR_DATA_W'(budget_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         count_ff     <= '0;
         budget_ff    <= BUDGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         count_ff     <= count_in;
         budget_ff    <= budget_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fired_ff    <= fired_in;
      pend_ff     <= pend_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_full_ff <= rsp_full_in;
      rsp_due_ff  <= rsp_due_in;
      rsp_adv_ff  <= rsp_adv_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.fired_tag     = rsp_tag_ff;
   assign rsp_chan.queue_full    = rsp_full_ff;
   assign rsp_chan.due_remaining = rsp_due_ff;
   assign rsp_chan.tick_advanced = rsp_adv_ff;
   assign rsp_chan.last          = rsp_last_ff;

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(QUEUE_DEPTH))
   `ASSERT_CLK(a_head_sorted, clock, reset,
      (count_ff > CNT_W'(1)) |-> (entries[0].due <= entries[1].due))
   `ASSERT_CLK(a_tick_step, clock, reset,
      ((tick_ff != $past(tick_ff)) && !$past(reset)) |->
      (tick_ff == $past(tick_ff) + TICK_W'(1)))
   `ASSERT_CLK(a_pop_count, clock, reset,
      ctrl.pop |=> (count_ff == $past(count_ff) - CNT_W'(1)))

endmodule

### dv/tick_event_queue_tb.sv
// tick event queue testbench: directed table and random items checked against a predictor
module tick_event_queue_tb import tevq_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH    = 64;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 16;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;
   localparam int MIX_ITEMS      = 2;
   localparam int DIRECTED_ROWS  = 21;
   localparam int PHASES         = 7;
   localparam int STEADY_PHASE   = 1;

   localparam logic [ACTION_W-1:0]   ACT_UNUSED        = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SLICE_BUDGET = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE        = 3'd4;

   typedef struct packed {
      kind_type         kind;
      logic [TAG_W-1:0] tag;
      logic             full;
      logic             due_left;
      logic             advanced;
      logic             last;
   } result_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [DELAY_W-1:0]  delay;
      logic [TAG_W-1:0]    tag;
      logic                typed;
      result_type          want;
   } stim_row_type;

   localparam result_type ACK_OK   = '{KIND_ACK, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1};
   localparam result_type ACK_FULL = '{KIND_ACK, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1};
   localparam result_type IDLE_ADV = '{KIND_IDLE, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1};
   localparam result_type CLEAR_OK = '{KIND_CLEAR, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1};
   localparam result_type NO_TYPED = '0;

   localparam stim_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{ACT_SLICE,  20'h00000, 16'h0000, 1'b1, IDLE_ADV},
      '{ACT_INSERT, 20'h00000, 16'hFFFF, 1'b1, ACK_OK},
      '{ACT_INSERT, 20'h00000, 16'h0000, 1'b1, ACK_OK},
      '{ACT_INSERT, 20'hFFFFF, 16'h1234, 1'b1, ACK_OK},
      '{ACT_INSERT, 20'h00001, 16'hAAAA, 1'b1, ACK_OK},
      '{ACT_INSERT, 20'h00000, 16'h5555, 1'b1, ACK_OK},
      '{ACT_SLICE,  20'hFFFFF, 16'hFFFF, 1'b0, NO_TYPED},
      '{ACT_UNUSED, 20'h5A5A5, 16'hA5A5, 1'b0, NO_TYPED},
      '{ACT_SLICE,  20'h00000, 16'h0000, 1'b0, NO_TYPED},
      '{ACT_SLICE,  20'h00000, 16'h0000, 1'b1, IDLE_ADV},
      '{ACT_CLEAR,  20'hFFFFF, 16'hFFFF, 1'b1, CLEAR_OK},
      '{ACT_SLICE,  20'h00000, 16'h0000, 1'b1, IDLE_ADV},
      '{ACT_INSERT, 20'h00000, 16'h00FF, 1'b1, ACK_OK},
      '{ACT_INSERT, 20'h00000, 16'hFF00, 1'b1, ACK_OK},
      '{ACT_INSERT, 20'h00002, 16'h0F0F, 1'b1, ACK_OK},
      '{ACT_INSERT, 20'h00000, 16'hF0F0, 1'b1, ACK_OK},
      '{ACT_SLICE,  20'h00000, 16'h0000, 1'b0, NO_TYPED},
      '{ACT_SLICE,  20'h00000, 16'h0000, 1'b0, NO_TYPED},
      '{ACT_SLICE,  20'h00000, 16'h0000, 1'b0, NO_TYPED},
      '{ACT_UNUSED, 20'hFFFFF, 16'hFFFF, 1'b0, NO_TYPED},
      '{ACT_CLEAR,  20'h00000, 16'h0000, 1'b1, CLEAR_OK}
   };

   localparam logic [BUDGET_W-1:0] PHASE_BUDGETS [PHASES-1] = '{
      7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd16
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tevq_req_if req_if ();
   tevq_rsp_if rsp_if ();

   entry_type           queued_events[$];
   logic [TICK_W-1:0]   tick_now;
   logic [BUDGET_W-1:0] budget_reg;
   result_type          pending_results[$];
   logic                offer_typed;
   result_type          offer_want;
   bit                  steady;
   bit                  rx_hold_request;
   int                  mismatch_count;

   tick_event_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit head_is_due();
      return queued_events.size() > 0 && queued_events[0].due <= tick_now;
   endfunction

   function automatic void queue_result(input result_type res);
      pending_results = {pending_results, res};
   endfunction

   function automatic void predict_item(input logic [ACTION_W-1:0] action,
                                        input logic [DELAY_W-1:0] delay,
                                        input logic [TAG_W-1:0] tag);
      entry_type        fresh;
      int               pos;
      int               limit;
      logic [TAG_W-1:0] fired[$];
      logic             due_left;
      result_type       res;
      case (action)
         ACT_INSERT: begin
            if (queued_events.size() >= QUEUE_DEPTH) begin
               queue_result(ACK_FULL);
            end else begin
               fresh.due = tick_now + TICK_W'(delay);
               fresh.tag = tag;
               pos = queued_events.size();
               while (pos > 0 && queued_events[pos-1].due > fresh.due) pos--;
               queued_events.insert(pos, fresh);
               queue_result(ACK_OK);
            end
         end
         ACT_SLICE: begin
            if (budget_reg < BUDGET_MIN) limit = int'(BUDGET_MIN);
            else if (budget_reg > BUDGET_MAX) limit = int'(BUDGET_MAX);
            else limit = int'(budget_reg);
            while (fired.size() < limit && head_is_due()) begin
               fired = {fired, queued_events[0].tag};
               void'(queued_events.pop_front());
            end
            due_left = head_is_due();
            if (!due_left) tick_now = tick_now + TICK_W'(1);
            if (fired.size() == 0) begin
               res = '{KIND_IDLE, 16'h0000, 1'b0, due_left, !due_left, 1'b1};
               queue_result(res);
            end else begin
               foreach (fired[i]) begin
                  res = '{KIND_FIRED, fired[i], 1'b0, 1'b0, 1'b0, 1'b0};
                  if (i == fired.size() - 1) begin
                     res.due_left = due_left;
                     res.advanced = !due_left;
                     res.last     = 1'b1;
                  end
                  queue_result(res);
               end
            end
         end
         ACT_CLEAR: begin
            queued_events.delete();
            queue_result(CLEAR_OK);
         end
         default: ;
      endcase
   endfunction

   function automatic void note_mismatch(input string what, input result_type want,
                                         input result_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t %s: expected kind %0d tag %h full %b due %b adv %b last %b",
                  $realtime, what, want.kind, want.tag, want.full, want.due_left,
                  want.advanced, want.last);
         $display("%0t %s: actual   kind %0d tag %h full %b due %b adv %b last %b",
                  $realtime, what, got.kind, got.tag, got.full, got.due_left,
                  got.advanced, got.last);
      end
   endfunction

   function automatic logic [DELAY_W-1:0] pick_delay();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return DELAY_W'($urandom_range(0, 3));
         6, 7:             return DELAY_W'($urandom_range(0, 40));
         8:                return {DELAY_W{1'b1}};
         default:          return DELAY_W'($urandom());
      endcase
   endfunction

   // check accepted results and predict on accepted items
   always @(posedge clock) begin
      int         prior;
      result_type got;
      result_type want;
      if (!reset && req_if.valid && req_if.ready) begin
         prior = pending_results.size();
         predict_item(req_if.action, req_if.delay, req_if.event_tag);
         if (offer_typed) begin
            while (pending_results.size() > prior) void'(pending_results.pop_back());
            queue_result(offer_want);
         end
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{kind_type'(rsp_if.kind), rsp_if.fired_tag, rsp_if.queue_full,
                 rsp_if.due_remaining, rsp_if.tick_advanced, rsp_if.last};
         if (pending_results.size() == 0) begin
            note_mismatch("result with no item waiting", NO_TYPED, got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) note_mismatch("result mismatch", want, got);
         end
      end
   end

   // receiver: random ready, or always ready in the steady phase, with one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (RX_HOLD_CYCLES - 1) @(negedge clock);
            rx_hold_request = 1'b0;
         end else if (steady) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("tick_event_queue test failed");
      $finish;
   end

   task automatic offer_item(input logic [ACTION_W-1:0] action,
                             input logic [DELAY_W-1:0] delay,
                             input logic [TAG_W-1:0] tag,
                             input logic typed = 1'b0,
                             input result_type want = '0);
      if (!steady) begin
         while ($urandom_range(0, 2) == 0) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.action    <= action;
      req_if.delay     <= delay;
      req_if.event_tag <= tag;
      offer_typed      <= typed;
      offer_want       <= want;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   task automatic drain_results(input int pad);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (pad) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr[CSR_INDEX_BIT] == REG_SLICE_BUDGET) budget_reg = data[BUDGET_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic run_mix(input int count);
      int                  sent;
      int                  burst;
      int                  slices;
      logic [ACTION_W-1:0] action;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               burst  = $urandom_range(1, 3);
               slices = $urandom_range(1, 2);
               repeat (burst) offer_item(ACT_INSERT, pick_delay(), TAG_W'($urandom()));
               repeat (slices) begin
                  offer_item(ACT_SLICE, DELAY_W'($urandom()), TAG_W'($urandom()));
               end
               sent += burst + slices;
            end
            6: begin
               offer_item(ACT_CLEAR, DELAY_W'($urandom()), TAG_W'($urandom()));
               sent++;
            end
            7: begin
               offer_item(ACT_UNUSED, DELAY_W'($urandom()), TAG_W'($urandom()));
               sent++;
            end
            8: drain_results(0);
            default: begin
               action = ACTION_W'($urandom_range(0, 3));
               offer_item(action, DELAY_W'($urandom()), TAG_W'($urandom()));
               sent++;
            end
         endcase
      end
   endtask

   initial begin
      logic [BUDGET_W-1:0] budget;
      reset            = 1'b1;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_if.valid     = 1'b0;
      req_if.action    = '0;
      req_if.delay     = '0;
      req_if.event_tag = '0;
      offer_typed      = 1'b0;
      offer_want       = '0;
      steady           = 1'b0;
      rx_hold_request  = 1'b0;
      mismatch_count   = 0;
      tick_now         = '0;
      budget_reg       = BUDGET_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         offer_item(DIRECTED_TABLE[i].action, DIRECTED_TABLE[i].delay,
                    DIRECTED_TABLE[i].tag, DIRECTED_TABLE[i].typed, DIRECTED_TABLE[i].want);
      end
      drain_results(SETTLE_CYCLES);

      // unmapped register index, must leave the budget alone
      write_csr(ADDR_SPARE, $urandom());

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) budget = BUDGET_W'($urandom_range(1, int'(BUDGET_MAX)));
         else budget = PHASE_BUDGETS[p];
         write_csr(ADDR_SLICE_BUDGET, ($urandom() & ~32'h7F) | CSR_DATA_W'(budget));
         steady = (p == STEADY_PHASE);
         if (budget == BUDGET_MAX) begin
            // fill one past full, then one slice pops every slot, stalled by a receiver hold-off
            offer_item(ACT_CLEAR, DELAY_W'($urandom()), TAG_W'($urandom()));
            repeat (QUEUE_DEPTH + 1) offer_item(ACT_INSERT, '0, TAG_W'($urandom()));
            rx_hold_request = 1'b1;
            offer_item(ACT_SLICE, DELAY_W'($urandom()), TAG_W'($urandom()));
         end
         run_mix(MIX_ITEMS);
         drain_results(SETTLE_CYCLES);
      end
      steady = 1'b0;

      drain_results(END_CYCLES);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tick_event_queue test passed");
      end else begin
         $display("tick_event_queue test failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/tevq_pkg.sv
rtl/tevq_req_if.sv
rtl/tevq_rsp_if.sv
rtl/tevq_cell.sv
rtl/tick_event_queue.sv
dv/tick_event_queue_tb.sv
